// ----- rtl/core/skt_pkg.sv -----
`timescale 1ns / 1ps

package skt_pkg;

    localparam int KEY_W    = 64;
    localparam int OWNER_W  = 64;
    localparam int STATE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUP       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_START = 2'd1,
        S_SCAN  = 2'd2,
        S_SHIFT = 2'd3
    } t_ctrl_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
        logic [STATE_W-1:0] state;
    } t_record;

    typedef struct packed {
        logic    load;
        logic    scan_rd;
        logic    advance;
        logic    shift_begin;
        logic    pos_next;
        logic    shift_step;
        logic    commit;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
        logic full;
        logic at_end;
        logic hit;
        logic greater;
        logic last;
        logic shift_done;
    } t_dp_stat;

endpackage

// ----- rtl/core/skt_datapath.sv -----
`timescale 1ns / 1ps

module skt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skt_pkg::t_dp_cmd                  i_cmd,
    output skt_pkg::t_dp_stat                 o_stat,
    input  logic                              i_cfg_we,
    input  logic [skt_pkg::CAP_W-1:0]         i_cfg_capacity_limit,
    input  logic                              i_command,
    input  logic [skt_pkg::KEY_W-1:0]         i_key_id,
    input  logic [skt_pkg::OWNER_W-1:0]       i_owner_id,
    input  logic [skt_pkg::STATE_W-1:0]       i_state_word,
    output logic [skt_pkg::STATUS_W-1:0]      o_status,
    output logic [skt_pkg::OWNER_W-1:0]       o_found_owner_id,
    output logic [skt_pkg::STATE_W-1:0]       o_found_state_word,
    output logic [skt_pkg::INDEX_W-1:0]       o_entry_index
);
    import skt_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    t_record            mem [TABLE_DEPTH];
    t_record            r_rd;
    t_record            r_req;
    logic               r_is_lookup;
    logic [CAP_W-1:0]   r_cap;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_pos;

    logic [STATUS_W-1:0] r_out_status;
    logic [OWNER_W-1:0]  r_out_owner;
    logic [STATE_W-1:0]  r_out_state;
    logic [INDEX_W-1:0]  r_out_index;

    logic [CW-1:0]   ptr_inc;
    logic [CW-1:0]   ptr_dec;
    logic [CW-1:0]   rd_addr;
    logic            rd_en;
    logic [CW-1:0]   wr_addr;
    t_record         wr_data;
    logic            wr_en;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] depth_ext;
    logic [CMPW-1:0] cap_eff;
    logic [CW-1:0]   n_pos;
    logic [CW-1:0]   res_pos;
    logic [CMPW-1:0] res_pos_ext;
    logic            res_found;

    assign ptr_inc = r_ptr + CW'(1);
    assign ptr_dec = r_ptr - CW'(1);
    assign n_pos   = i_cmd.pos_next ? ptr_inc : r_ptr;

    always_comb begin
        cap_ext   = CMPW'(r_cap);
        depth_ext = CMPW'(TABLE_DEPTH);
        cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_ptr;
        if (i_cmd.advance) begin
            rd_addr = ptr_inc;
        end else if (i_cmd.shift_begin) begin
            rd_addr = r_count - CW'(1);
        end else if (i_cmd.shift_step) begin
            rd_addr = r_ptr - CW'(2);
        end else if (!i_cmd.scan_rd) begin
            rd_en = 1'b0;
        end
    end

    always_comb begin
        wr_en   = i_cmd.shift_step | i_cmd.commit;
        wr_addr = i_cmd.commit ? r_pos : r_ptr;
        wr_data = i_cmd.commit ? r_req : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
            r_ptr   <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_capacity_limit;
            end
            if (i_cmd.commit) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (i_cmd.advance) begin
                r_ptr <= ptr_inc;
            end else if (i_cmd.shift_begin) begin
                r_ptr <= r_count;
            end else if (i_cmd.shift_step) begin
                r_ptr <= ptr_dec;
            end
            if (i_cmd.shift_begin) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_lookup <= (i_command == CMD_LOOKUP);
            r_req.key   <= i_key_id;
            r_req.owner <= i_owner_id;
            r_req.state <= i_state_word;
        end
    end

    always_comb begin
        res_found   = (i_cmd.res_status == ST_OK) && r_is_lookup;
        res_pos     = '0;
        if (res_found || (i_cmd.res_status == ST_DUP)) begin
            res_pos = r_ptr;
        end else if (i_cmd.res_status == ST_OK) begin
            res_pos = r_pos;
        end
        res_pos_ext = CMPW'(res_pos);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_owner  <= res_found ? r_rd.owner : '0;
            r_out_state  <= res_found ? r_rd.state : '0;
            r_out_index  <= res_pos_ext[INDEX_W-1:0];
        end
    end

    always_comb begin
        o_stat.is_lookup  = r_is_lookup;
        o_stat.full       = CMPW'(r_count) >= cap_eff;
        o_stat.at_end     = (r_ptr == r_count);
        o_stat.hit        = (r_rd.key == r_req.key);
        o_stat.greater    = (r_rd.key > r_req.key);
        o_stat.last       = (ptr_inc == r_count);
        o_stat.shift_done = (r_ptr == r_pos);
    end

    assign o_status           = r_out_status;
    assign o_found_owner_id   = r_out_owner;
    assign o_found_state_word = r_out_state;
    assign o_entry_index      = r_out_index;

endmodule

// ----- rtl/core/skt_ctrl.sv -----
`timescale 1ns / 1ps

module skt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  skt_pkg::t_dp_stat  i_stat,
    output skt_pkg::t_dp_cmd   o_cmd
);
    import skt_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        o_in_ready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (!i_stat.is_lookup && i_stat.full) begin
                    if (out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.at_end) begin
                    if (!i_stat.is_lookup) begin
                        o_cmd.shift_begin = 1'b1;
                        n_state           = S_SHIFT;
                    end else if (out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    if (out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = i_stat.is_lookup ? ST_OK : ST_DUP;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.greater || i_stat.last) begin
                    if (!i_stat.is_lookup) begin
                        o_cmd.shift_begin = 1'b1;
                        o_cmd.pos_next    = !i_stat.greater;
                        n_state           = S_SHIFT;
                    end else if (out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    if (out_free) begin
                        o_cmd.commit     = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/sorted_key_table_insert_lookup.sv -----
`timescale 1ns / 1ps

// Sorted key table: up to TABLE_DEPTH records kept in ascending key order in a
// record memory with one read and one write port. One request at a time: a
// request scans the entries in order, stopping at a match, a larger key or the
// last entry, and an insert then moves the records above the insert point up
// one place and writes the new record. The scan and the move each use the
// single read port once per entry. The next request is taken while the
// previous result waits on the output register. Data read from entries above
// the record count is never used, so the memory needs no clearing after reset.
module sorted_key_table_insert_lookup #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [skt_pkg::CAP_W-1:0]         i_cfg_capacity_limit,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [skt_pkg::KEY_W-1:0]         i_key_id,
    input  logic [skt_pkg::OWNER_W-1:0]       i_owner_id,
    input  logic [skt_pkg::STATE_W-1:0]       i_state_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [skt_pkg::STATUS_W-1:0]      o_status,
    output logic [skt_pkg::OWNER_W-1:0]       o_found_owner_id,
    output logic [skt_pkg::STATE_W-1:0]       o_found_state_word,
    output logic [skt_pkg::INDEX_W-1:0]       o_entry_index
);
    import skt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    skt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .o_stat               (dp_stat),
        .i_cfg_we             (i_cfg_valid & o_cfg_ready),
        .i_cfg_capacity_limit (i_cfg_capacity_limit),
        .i_command            (i_command),
        .i_key_id             (i_key_id),
        .i_owner_id           (i_owner_id),
        .i_state_word         (i_state_word),
        .o_status             (o_status),
        .o_found_owner_id     (o_found_owner_id),
        .o_found_state_word   (o_found_state_word),
        .o_entry_index        (o_entry_index)
    );

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.scan_rd, dp_cmd.advance, dp_cmd.shift_begin,
                  dp_cmd.shift_step, dp_cmd.commit}))
        else $error("more than one table operation in a cycle");

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in progress");

    a_not_found_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.res_load && dp_cmd.res_status == ST_NOT_FOUND) |-> dp_stat.is_lookup)
        else $error("not-found reported for an insert");

endmodule

// ----- bench/tb_sorted_key_table_insert_lookup.sv -----
`timescale 1ns / 1ps

module tb_sorted_key_table_insert_lookup;
    import skt_pkg::*;

    localparam int DEPTH = 64;
    localparam int DIR_N = 25;
    localparam int PHASE_N = 7;
    localparam int PHASE_ITEMS = 62;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct packed {
        t_status              status;
        logic [OWNER_W-1:0]   owner;
        logic [STATE_W-1:0]   state;
        logic [INDEX_W-1:0]   index;
    } t_reply;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CAP_W-1:0]     cap;
        logic                 cmd;
        logic [KEY_W-1:0]     key;
        logic [OWNER_W-1:0]   owner;
        logic [STATE_W-1:0]   sword;
        logic                 fixed;
        t_reply               reply;
    } t_step_row;

    localparam t_step_row DIR_ROWS [DIR_N] = '{
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'd0, 64'd0, 32'd0,
          1'b1, '{ST_NOT_FOUND, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd5, '1, '1,
          1'b1, '{ST_OK, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd0, 64'd0, 32'd0,
          1'b1, '{ST_OK, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_INSERT, KEY_MAX, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A,
          1'b1, '{ST_OK, 64'd0, 32'd0, 6'd2}},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd5, 64'd1, 32'd1,
          1'b1, '{ST_DUP, 64'd0, 32'd0, 6'd1}},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'd5, 64'd0, 32'd0,
          1'b1, '{ST_OK, '1, '1, 6'd1}},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'd0, 64'd0, 32'd0,
          1'b1, '{ST_OK, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, KEY_MAX, 64'd0, 32'd0,
          1'b1, '{ST_OK, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 6'd2}},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'd3, 64'd0, 32'd0,
          1'b1, '{ST_NOT_FOUND, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, KEY_MAX - 64'd1, 64'd0, 32'd0,
          1'b1, '{ST_NOT_FOUND, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd3, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF,
          1'b1, '{ST_OK, 64'd0, 32'd0, 6'd1}},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'h8000_0000_0000_0000, 64'hFEDC_BA98_7654_3210,
          32'h8000_0001, 1'b0, '0},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'd3, 64'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG, 7'd0, CMD_INSERT, 64'd0, 64'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd7, 64'd7, 32'd7,
          1'b1, '{ST_FULL, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG, 7'd5, CMD_INSERT, 64'd0, 64'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd9, 64'd9, 32'd9,
          1'b1, '{ST_FULL, 64'd0, 32'd0, 6'd0}},
        '{ROW_CFG, 7'd6, CMD_INSERT, 64'd0, 64'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd4, 64'd1, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_REQ, 7'd0, CMD_INSERT, 64'd10, 64'd10, 32'd10,
          1'b1, '{ST_FULL, 64'd0, 32'd0, 6'd0}},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'd4, 64'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG, 7'd127, CMD_INSERT, 64'd0, 64'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, 7'd0, CMD_INSERT, KEY_MAX, 64'd2, 32'd2, 1'b0, '0},
        '{ROW_REQ, 7'd0, CMD_LOOKUP, 64'd1, 64'd0, 32'd0,
          1'b1, '{ST_NOT_FOUND, 64'd0, 32'd0, 6'd0}}
    };

    localparam logic [CAP_W-1:0] PHASE_CAPS [PHASE_N] = '{
        7'd10, 7'd30, 7'd127, 7'd40, 7'd64, 7'd0, 7'd127
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CAP_W-1:0]      i_cfg_capacity_limit;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_command;
    logic [KEY_W-1:0]      i_key_id;
    logic [OWNER_W-1:0]    i_owner_id;
    logic [STATE_W-1:0]    i_state_word;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    logic [STATUS_W-1:0]   o_status;
    logic [OWNER_W-1:0]    o_found_owner_id;
    logic [STATE_W-1:0]    o_found_state_word;
    logic [INDEX_W-1:0]    o_entry_index;

    logic [KEY_W-1:0]      rec_key [DEPTH];
    logic [OWNER_W-1:0]    rec_owner [DEPTH];
    logic [STATE_W-1:0]    rec_state [DEPTH];
    int unsigned           rec_count = 0;
    logic [CAP_W-1:0]      cap_setting = CAP_RESET;

    t_reply                pending_replies [$];
    t_reply                expected_reply;
    int unsigned           mismatch_count = 0;
    int unsigned           tx_sent = 0;
    int unsigned           rx_seen = 0;
    int unsigned           rx_hold = 0;
    int unsigned           rx_stall;

    sorted_key_table_insert_lookup #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_capacity_limit (i_cfg_capacity_limit),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_command            (i_command),
        .i_key_id             (i_key_id),
        .i_owner_id           (i_owner_id),
        .i_state_word         (i_state_word),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_status             (o_status),
        .o_found_owner_id     (o_found_owner_id),
        .o_found_state_word   (o_found_state_word),
        .o_entry_index        (o_entry_index)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_reply table_result(input logic cmd, input logic [KEY_W-1:0] key,
                                            input logic [OWNER_W-1:0] owner,
                                            input logic [STATE_W-1:0] sword);
        t_reply      r;
        int unsigned pos;
        int unsigned limit;
        int unsigned i;
        bit          hit;
        r = '0;
        r.status = ST_OK;
        limit = (cap_setting > DEPTH) ? DEPTH : cap_setting;
        pos = 0;
        hit = 1'b0;
        while (pos < rec_count && !hit && rec_key[pos] <= key) begin
            if (rec_key[pos] == key) begin
                hit = 1'b1;
            end else begin
                pos++;
            end
        end
        if (cmd == CMD_INSERT) begin
            if (rec_count >= limit) begin
                r.status = ST_FULL;
            end else if (hit) begin
                r.status = ST_DUP;
                r.index = INDEX_W'(pos);
            end else begin
                for (i = rec_count; i > pos; i--) begin
                    rec_key[i] = rec_key[i-1];
                    rec_owner[i] = rec_owner[i-1];
                    rec_state[i] = rec_state[i-1];
                end
                rec_key[pos] = key;
                rec_owner[pos] = owner;
                rec_state[pos] = sword;
                rec_count++;
                r.index = INDEX_W'(pos);
            end
        end else if (hit) begin
            r.owner = rec_owner[pos];
            r.state = rec_state[pos];
            r.index = INDEX_W'(pos);
        end else begin
            r.status = ST_NOT_FOUND;
        end
        return r;
    endfunction

    task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                                input logic [OWNER_W-1:0] owner,
                                input logic [STATE_W-1:0] sword,
                                input logic fixed, input t_reply fixed_reply);
        t_reply      predicted;
        int unsigned gap;
        gap = ((tx_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_key_id <= key;
        i_owner_id <= owner;
        i_state_word <= sword;
        // hold the request until it is taken
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        predicted = table_result(cmd, key, owner, sword);
        pending_replies.push_back(fixed ? fixed_reply : predicted);
        tx_sent++;
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_capacity_limit <= cap;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_setting = cap;
    endtask

    task automatic send_random();
        logic             cmd;
        logic [KEY_W-1:0] key;
        int unsigned      roll;
        int unsigned      hit_pct;
        cmd = ($urandom_range(0, 99) < 45) ? CMD_LOOKUP : CMD_INSERT;
        hit_pct = (cmd == CMD_LOOKUP) ? 50 : 15;
        roll = $urandom_range(0, 99);
        if (rec_count != 0 && roll < hit_pct) begin
            key = rec_key[$urandom_range(0, rec_count - 1)];
        end else if (rec_count != 0 && roll < hit_pct + 20) begin
            // near miss: neighbour of a stored key
            key = rec_key[$urandom_range(0, rec_count - 1)];
            key = roll[0] ? key + 64'd1 : key - 64'd1;
        end else if (roll >= 95) begin
            key = roll[0] ? KEY_MAX : '0;
        end else begin
            key = {$urandom, $urandom};
        end
        send_request(cmd, key, {$urandom, $urandom}, $urandom, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: st=%0d owner=%h word=%h idx=%0d",
                             o_status, o_found_owner_id, o_found_state_word, o_entry_index);
                end
            end else begin
                expected_reply = pending_replies.pop_front();
                if (o_status !== expected_reply.status
                        || o_found_owner_id !== expected_reply.owner
                        || o_found_state_word !== expected_reply.state
                        || o_entry_index !== expected_reply.index) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at result %0d: exp st=%0d owner=%h word=%h idx=%0d",
                                 rx_seen, expected_reply.status, expected_reply.owner,
                                 expected_reply.state, expected_reply.index);
                        $display("    got st=%0d owner=%h word=%h idx=%0d",
                                 o_status, o_found_owner_id, o_found_state_word,
                                 o_entry_index);
                    end
                end
            end
            rx_seen++;
            rx_stall = ((rx_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
            if (rx_stall != 0) begin
                i_out_ready <= 1'b0;
                rx_hold <= rx_stall;
            end
        end else if (!i_out_ready) begin
            if (rx_hold <= 1) begin
                i_out_ready <= 1'b1;
            end
            rx_hold <= rx_hold - 1;
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_capacity_limit <= '0;
        i_in_valid <= 1'b0;
        i_command <= CMD_INSERT;
        i_key_id <= '0;
        i_owner_id <= '0;
        i_state_word <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                write_capacity(DIR_ROWS[r].cap);
            end else begin
                send_request(DIR_ROWS[r].cmd, DIR_ROWS[r].key, DIR_ROWS[r].owner,
                             DIR_ROWS[r].sword, DIR_ROWS[r].fixed, DIR_ROWS[r].reply);
            end
        end

        for (int p = 0; p < PHASE_N; p++) begin
            write_capacity(PHASE_CAPS[p]);
            repeat (PHASE_ITEMS) send_random();
        end

        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/skt_pkg.sv
rtl/core/skt_datapath.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table_insert_lookup.sv
bench/tb_sorted_key_table_insert_lookup.sv
